// ===== hw/rtl/lcabl_pkg.sv =====
package lcabl_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int JUMP_LEVELS = 11;
  localparam int NODE_W      = 10;
  localparam int LEVEL_W     = 10;
  localparam int K_W         = $clog2(JUMP_LEVELS);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [K_W-1:0]     kidx_t;

  localparam level_t LEVEL_MAX = '1;
  localparam node_t  LAST_NODE = NODE_W'(MAX_NODES - 1);
  localparam kidx_t  K_TOP     = K_W'(JUMP_LEVELS - 1);

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    level_t                       level;
    node_t [JUMP_LEVELS-1:0]      anc;
  } row_t;

  typedef struct packed {
    logic  we;
    node_t waddr;
    row_t  wdata;
    node_t raddr_a;
    node_t raddr_b;
  } tbl_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_LOAD,
    ST_Q_UP,
    ST_Q_CHK,
    ST_Q_BOTH,
    ST_Q_FIN,
    ST_A_FILL,
    ST_A_WR,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/lcabl_table.sv =====
module lcabl_table (
  input  logic                clk,
  input  lcabl_pkg::tbl_req_t req,
  output lcabl_pkg::row_t     rd_a,
  output lcabl_pkg::row_t     rd_b
);
  import lcabl_pkg::*;

  row_t mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

// ===== hw/rtl/lcabl_ctrl.sv =====
module lcabl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  lcabl_pkg::node_t    node,
  input  lcabl_pkg::node_t    parent,
  input  lcabl_pkg::node_t    query_u,
  input  lcabl_pkg::node_t    query_v,
  output logic                out_valid,
  input  logic                out_stall,
  output lcabl_pkg::node_t    ancestor,
  output lcabl_pkg::level_t   depth,
  output lcabl_pkg::tbl_req_t tbl_req,
  input  lcabl_pkg::row_t     rd_a,
  input  lcabl_pkg::row_t     rd_b
);
  import lcabl_pkg::*;

  state_t state, state_next;
  kidx_t  k, k_next;
  node_t  cur_id, cur_id_next;
  node_t  v_id, v_id_next;
  row_t   u_row, u_row_next;
  row_t   v_row, v_row_next;
  node_t  clr_idx, clr_idx_next;
  node_t  res_id, res_id_next;
  level_t res_lvl, res_lvl_next;
  logic   out_valid_next;
  node_t  ancestor_next;
  level_t depth_next;
  kidx_t  k_dn;
  kidx_t  k_up;

  assign k_dn     = k - 1'b1;
  assign k_up     = k + 1'b1;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    cur_id   <= cur_id_next;
    v_id     <= v_id_next;
    u_row    <= u_row_next;
    v_row    <= v_row_next;
    res_id   <= res_id_next;
    res_lvl  <= res_lvl_next;
    ancestor <= ancestor_next;
    depth    <= depth_next;
  end

  always_comb begin
    row_t  nu;
    row_t  nv;
    node_t up;
    node_t au;
    node_t av;
    node_t x;
    node_t fill;
    state_next     = state;
    k_next         = k;
    cur_id_next    = cur_id;
    v_id_next      = v_id;
    u_row_next     = u_row;
    v_row_next     = v_row;
    clr_idx_next   = clr_idx;
    res_id_next    = res_id;
    res_lvl_next   = res_lvl;
    out_valid_next = out_valid;
    ancestor_next  = ancestor;
    depth_next     = depth;
    tbl_req        = '0;
    nu             = u_row;
    nv             = v_row;
    up             = u_row.anc[k];
    au             = u_row.anc[k];
    av             = v_row.anc[k];
    x              = u_row.anc[k_dn];
    fill           = rd_a.anc[k_dn];

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = clr_idx;
        clr_idx_next  = clr_idx + 1'b1;
        if (clr_idx == LAST_NODE) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_QUERY) begin
            cur_id_next     = query_u;
            v_id_next       = query_v;
            tbl_req.raddr_a = query_u;
            tbl_req.raddr_b = query_v;
            state_next      = ST_Q_LOAD;
          end else if (node == '0) begin
            res_id_next  = '0;
            res_lvl_next = '0;
            state_next   = ST_DONE;
          end else begin
            cur_id_next        = node;
            u_row_next.anc[0]  = parent;
            tbl_req.raddr_a    = parent;
            k_next             = kidx_t'(1);
            state_next         = ST_A_FILL;
          end
        end
      end
      ST_Q_LOAD: begin
        // deeper node goes to the u side
        if (rd_a.level < rd_b.level) begin
          nu          = rd_b;
          nv          = rd_a;
          cur_id_next = v_id;
          v_id_next   = cur_id;
        end else begin
          nu = rd_a;
          nv = rd_b;
        end
        u_row_next      = nu;
        v_row_next      = nv;
        k_next          = K_TOP;
        tbl_req.raddr_a = nu.anc[K_TOP];
        state_next      = ST_Q_UP;
      end
      ST_Q_UP: begin
        if (rd_a.level >= v_row.level) begin
          nu          = rd_a;
          cur_id_next = up;
        end
        u_row_next = nu;
        if (k == '0) begin
          state_next = ST_Q_CHK;
        end else begin
          k_next          = k_dn;
          tbl_req.raddr_a = nu.anc[k_dn];
        end
      end
      ST_Q_CHK: begin
        if (cur_id == v_id) begin
          res_id_next  = cur_id;
          res_lvl_next = u_row.level;
          state_next   = ST_DONE;
        end else begin
          k_next          = K_TOP;
          tbl_req.raddr_a = u_row.anc[K_TOP];
          tbl_req.raddr_b = v_row.anc[K_TOP];
          state_next      = ST_Q_BOTH;
        end
      end
      ST_Q_BOTH: begin
        if (au != av) begin
          nu          = rd_a;
          nv          = rd_b;
          cur_id_next = au;
          v_id_next   = av;
        end
        u_row_next = nu;
        v_row_next = nv;
        if (k == '0) begin
          tbl_req.raddr_a = nu.anc[0];
          res_id_next     = nu.anc[0];
          state_next      = ST_Q_FIN;
        end else begin
          k_next          = k_dn;
          tbl_req.raddr_a = nu.anc[k_dn];
          tbl_req.raddr_b = nv.anc[k_dn];
        end
      end
      ST_Q_FIN: begin
        res_lvl_next = rd_a.level;
        state_next   = ST_DONE;
      end
      ST_A_FILL: begin
        if (k == kidx_t'(1)) begin
          u_row_next.level = (rd_a.level == LEVEL_MAX) ? LEVEL_MAX : rd_a.level + 1'b1;
        end
        // the row under construction is its own ancestor: use its fresh entry
        if (x == cur_id) begin
          fill = x;
        end
        u_row_next.anc[k] = fill;
        if (k == K_TOP) begin
          state_next = ST_A_WR;
        end else begin
          k_next          = k_up;
          tbl_req.raddr_a = fill;
        end
      end
      ST_A_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = cur_id;
        tbl_req.wdata = u_row;
        res_id_next   = cur_id;
        res_lvl_next  = u_row.level;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          ancestor_next  = res_id;
          depth_next     = res_lvl;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    tbl_req.we |-> (state == ST_CLEAR || state == ST_A_WR))
    else $error("table write outside clear or add");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result beat not from done state");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_UP || state == ST_Q_BOTH || state == ST_A_FILL) |-> k <= K_TOP)
    else $error("jump level index out of range");

  a_add_level: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A_WR) |=> res_lvl != '0)
    else $error("added node got level zero");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && req_type == REQ_QUERY) |=> state == ST_Q_LOAD)
    else $error("query did not start");
`endif

endmodule

// ===== hw/rtl/lca_binary_lifting_top.sv =====
// add: one jump-table read per level to fill the row, then one row write; node 0 is not stored
// query: one jump-table read per level per phase
// one item in flight; the next beat is taken once the result moves to the output register
// rst is synchronous, active high; afterwards a clearing pass over all MAX_NODES rows (1024)
// zeroes the table, with in_stall high throughout
module lca_binary_lifting_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  lcabl_pkg::node_t  node,
  input  lcabl_pkg::node_t  parent,
  input  lcabl_pkg::node_t  query_u,
  input  lcabl_pkg::node_t  query_v,
  output logic              out_valid,
  input  logic              out_stall,
  output lcabl_pkg::node_t  ancestor,
  output lcabl_pkg::level_t depth
);
  import lcabl_pkg::*;

  tbl_req_t tbl_req;
  row_t     rd_a;
  row_t     rd_b;

  lcabl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .node      (node),
    .parent    (parent),
    .query_u   (query_u),
    .query_v   (query_v),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ancestor  (ancestor),
    .depth     (depth),
    .tbl_req   (tbl_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  lcabl_table u_table (
    .clk  (clk),
    .req  (tbl_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

endmodule

// ===== sim/tb_lca_binary_lifting_top.sv =====
module tb_lca_binary_lifting_top;
  import lcabl_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PROBES    = 24;
  localparam int PHASE_BEATS = 50;
  localparam int PATH_LEN    = 200;

  typedef struct packed {
    node_t  anc;
    level_t dep;
  } lca_t;

  typedef struct packed {
    logic   rt;
    node_t  a;
    node_t  b;
    logic   typed;
    node_t  e_anc;
    level_t e_dep;
  } probe_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  logic   req_type  = REQ_ADD;
  node_t  node      = '0;
  node_t  parent    = '0;
  node_t  query_u   = '0;
  node_t  query_v   = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  node_t  ancestor;
  level_t depth;

  node_t  anc_tab [MAX_NODES][JUMP_LEVELS];
  level_t lvl_tab [MAX_NODES];
  lca_t   awaited [$];
  lca_t   got_exp;
  node_t  tree_q [$];
  bit     in_tree [MAX_NODES];

  int errs       = 0;
  int cycles     = 0;
  int send_idle  = 0;
  int recv_stall = 0;
  int hold_ask   = 0;
  int hold_seen  = 0;
  int hold_cnt   = 0;

  // a/b: node/parent for an add, u/v for a query
  probe_t probes [N_PROBES] = '{
    '{REQ_QUERY, 10'd5,    10'd7,    1'b1, 10'd0,    10'd0},
    '{REQ_QUERY, 10'd5,    10'd5,    1'b0, 10'd0,    10'd0},
    '{REQ_ADD,   10'd0,    10'd5,    1'b1, 10'd0,    10'd0},
    '{REQ_ADD,   10'd1,    10'd0,    1'b1, 10'd1,    10'd1},
    '{REQ_ADD,   10'd2,    10'd1,    1'b1, 10'd2,    10'd2},
    '{REQ_ADD,   10'd3,    10'd2,    1'b1, 10'd3,    10'd3},
    '{REQ_ADD,   10'd4,    10'd1,    1'b1, 10'd4,    10'd2},
    '{REQ_QUERY, 10'd3,    10'd4,    1'b1, 10'd1,    10'd1},
    '{REQ_QUERY, 10'd4,    10'd3,    1'b1, 10'd1,    10'd1},
    '{REQ_QUERY, 10'd3,    10'd3,    1'b1, 10'd3,    10'd3},
    '{REQ_QUERY, 10'd2,    10'd3,    1'b1, 10'd2,    10'd2},
    '{REQ_QUERY, 10'd1023, 10'd3,    1'b1, 10'd0,    10'd0},
    '{REQ_ADD,   10'd1023, 10'd4,    1'b1, 10'd1023, 10'd3},
    '{REQ_QUERY, 10'd1023, 10'd3,    1'b1, 10'd1,    10'd1},
    '{REQ_ADD,   10'd5,    10'd1023, 1'b1, 10'd5,    10'd4},
    '{REQ_QUERY, 10'd5,    10'd2,    1'b1, 10'd1,    10'd1},
    '{REQ_QUERY, 10'd0,    10'd0,    1'b1, 10'd0,    10'd0},
    '{REQ_QUERY, 10'd0,    10'd5,    1'b1, 10'd0,    10'd0},
    '{REQ_QUERY, 10'd1023, 10'd1023, 1'b1, 10'd1023, 10'd3},
    '{REQ_ADD,   10'd6,    10'd6,    1'b0, 10'd0,    10'd0},
    '{REQ_ADD,   10'd2,    10'd5,    1'b0, 10'd0,    10'd0},
    '{REQ_QUERY, 10'd2,    10'd3,    1'b0, 10'd0,    10'd0},
    '{REQ_ADD,   10'd1023, 10'd1023, 1'b0, 10'd0,    10'd0},
    '{REQ_QUERY, 10'd6,    10'd3,    1'b0, 10'd0,    10'd0}
  };

  lca_binary_lifting_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .node     (node),
    .parent   (parent),
    .query_u  (query_u),
    .query_v  (query_v),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ancestor (ancestor),
    .depth    (depth)
  );

  always #5 clk = ~clk;

  function automatic lca_t lca_of_request(input logic rt, input node_t a, input node_t b);
    node_t            x;
    node_t            y;
    node_t            t;
    node_t            up;
    logic [LEVEL_W:0] lv;
    lca_t             r;
    if (rt == REQ_ADD) begin
      r.anc = a;
      if (a != '0) begin
        anc_tab[a][0] = b;
        lv = {1'b0, lvl_tab[b]} + 1'b1;
        lvl_tab[a] = (lv > LEVEL_MAX) ? LEVEL_MAX : lv[LEVEL_W-1:0];
        for (int k = 1; k < JUMP_LEVELS; k++)
          anc_tab[a][k] = anc_tab[anc_tab[a][k-1]][k-1];
      end
    end else begin
      x = a;
      y = b;
      if (lvl_tab[x] < lvl_tab[y]) begin
        t = x;
        x = y;
        y = t;
      end
      for (int k = JUMP_LEVELS - 1; k >= 0; k--) begin
        up = anc_tab[x][k];
        if (lvl_tab[up] >= lvl_tab[y]) x = up;
      end
      if (x != y) begin
        for (int k = JUMP_LEVELS - 1; k >= 0; k--) begin
          if (anc_tab[x][k] != anc_tab[y][k]) begin
            t = anc_tab[x][k];
            y = anc_tab[y][k];
            x = t;
          end
        end
        x = anc_tab[x][0];
      end
      r.anc = x;
    end
    r.dep = lvl_tab[r.anc];
    return r;
  endfunction

  task automatic offer(input logic rt, input node_t a, input node_t b, input logic typed = 1'b0,
                       input node_t e_anc = '0, input level_t e_dep = '0);
    lca_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    node     <= (rt == REQ_ADD)   ? a : node_t'($urandom);
    parent   <= (rt == REQ_ADD)   ? b : node_t'($urandom);
    query_u  <= (rt == REQ_QUERY) ? a : node_t'($urandom);
    query_v  <= (rt == REQ_QUERY) ? b : node_t'($urandom);
    do @(posedge clk); while (in_stall !== 1'b0);
    r = lca_of_request(rt, a, b);
    if (typed) begin
      r.anc = e_anc;
      r.dep = e_dep;
    end
    awaited = {awaited, r};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (awaited.size() == 0) begin
        $display("%0t: beat with nothing awaited: ancestor %0d depth %0d",
                 $time, ancestor, depth);
        errs++;
      end else begin
        got_exp = awaited.pop_front();
        if (ancestor !== got_exp.anc) begin
          $display("%0t: ancestor expected %0d got %0d", $time, got_exp.anc, ancestor);
          errs++;
        end
        if (depth !== got_exp.dep) begin
          $display("%0t: depth expected %0d got %0d", $time, got_exp.dep, depth);
          errs++;
        end
      end
    end
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** lca_binary_lifting_top: FAILED **");
      $finish;
    end
  end

  initial begin
    node_t u;
    node_t v;
    node_t n;
    node_t p;
    int    roll;
    int    tree_cap;
    foreach (anc_tab[i, j]) anc_tab[i][j] = '0;
    foreach (lvl_tab[i]) lvl_tab[i] = '0;
    foreach (in_tree[i]) in_tree[i] = 1'b0;
    tree_cap = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i])
      offer(probes[i].rt, probes[i].a, probes[i].b, probes[i].typed,
            probes[i].e_anc, probes[i].e_dep);

    // one long path, then a back edge from its end to its first node
    for (int i = 1; i <= PATH_LEN; i++)
      offer(REQ_ADD, node_t'(i), node_t'(i - 1));
    offer(REQ_QUERY, node_t'(PATH_LEN), 10'd1);
    offer(REQ_QUERY, 10'd113, node_t'(PATH_LEN));
    repeat (20)
      offer(REQ_QUERY, node_t'($urandom_range(1, MAX_NODES - 1)),
            node_t'($urandom_range(1, MAX_NODES - 1)));
    offer(REQ_ADD, 10'd1, node_t'(PATH_LEN));
    offer(REQ_QUERY, 10'd1, node_t'(PATH_LEN));
    offer(REQ_QUERY, 10'd150, 10'd1);
    drain();

    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin
          send_idle = 0;
          recv_stall <= 0;
        end
        1: begin
          send_idle = 82;
          recv_stall <= 0;
        end
        2: begin
          send_idle = 0;
          recv_stall <= 82;
        end
        default: begin
          send_idle = 38;
          recv_stall <= 38;
        end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (m == 0 && i == 40) hold_ask <= hold_ask + 1;
        roll = $urandom_range(99);
        if (roll < 10) begin
          offer(1'($urandom_range(1)), node_t'($urandom), node_t'($urandom));
        end else if (tree_q.size() < 2 || tree_q.size() >= tree_cap || roll < 55) begin
          if (tree_q.size() >= tree_cap) begin
            foreach (tree_q[j]) in_tree[tree_q[j]] = 1'b0;
            tree_q.delete();
            tree_cap = $urandom_range(4, 60);
            p = '0;
          end else if ($urandom_range(1) == 1) begin
            p = tree_q[$];
          end else begin
            p = tree_q[$urandom_range(tree_q.size() - 1)];
          end
          do n = node_t'($urandom_range(1, MAX_NODES - 1)); while (in_tree[n]);
          in_tree[n] = 1'b1;
          tree_q = {tree_q, n};
          offer(REQ_ADD, n, p);
        end else begin
          u = tree_q[$urandom_range(tree_q.size() - 1)];
          v = ($urandom_range(7) == 0) ? u : tree_q[$urandom_range(tree_q.size() - 1)];
          offer(REQ_QUERY, u, v);
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errs == 0) begin
      $display("** lca_binary_lifting_top: PASSED **");
    end else begin
      $display("** lca_binary_lifting_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lcabl_pkg.sv
hw/rtl/lcabl_table.sv
hw/rtl/lcabl_ctrl.sv
hw/rtl/lca_binary_lifting_top.sv
sim/tb_lca_binary_lifting_top.sv
